[hw/rtl/keypad_code_entry_assert.svh]
// ----------------------------------------------------------------------------
// Keypad code entry assertion macros
// Shared concurrent assertion forms, clocked on clock and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef KEYPAD_CODE_ENTRY_ASSERT_SVH
`define KEYPAD_CODE_ENTRY_ASSERT_SVH

// Same-cycle implication.
`define KCE_ASSERT_SAME(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication.
`define KCE_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

[hw/rtl/kce_pkg.sv]
// ----------------------------------------------------------------------------
// Keypad code entry package
// Types and key constants shared by the scan logic and the top level.
// ----------------------------------------------------------------------------
package kce_pkg;

   typedef logic [3:0]  digit_type;
   typedef logic [11:0] key_vec_type;

   localparam int        KEY_COUNT   = 12;
   localparam int        DIGIT_KEYS  = 10;
   localparam int        KEY_CLEAR   = 10;
   localparam int        KEY_ENTER   = 11;
   localparam int        ENTER_ROW   = 3;
   localparam digit_type DIGIT_EMPTY = 4'd15;

   // Key index at each column and row of the keypad.
   localparam digit_type COL_KEYS [3][4] = '{
      '{4'd1, 4'd4, 4'd7, 4'd10},
      '{4'd2, 4'd5, 4'd8, 4'd0},
      '{4'd3, 4'd6, 4'd9, 4'd11}
   };

   typedef struct packed {
      key_vec_type held;
      key_vec_type held_prev;
      logic        wait_mode;
      digit_type   led;
   } kce_state_type;

endpackage

[hw/rtl/kce_step.sv]
// ----------------------------------------------------------------------------
// Keypad code entry scan step
// Next-state logic for one keypad scan: key marks, released-key handling,
// digit entry, submit and wait mode.
// ----------------------------------------------------------------------------
module kce_step import kce_pkg::*; #(
   parameter int CODE_DIGITS = 4
) (
   input  logic [3:0]    col0_rows,
   input  logic [3:0]    col1_rows,
   input  logic [3:0]    col2_rows,
   input  kce_state_type state_cur,
   input  digit_type     entry_cur  [CODE_DIGITS],
   output kce_state_type state_next,
   output digit_type     entry_next [CODE_DIGITS],
   output logic          submit
);

   always_comb begin
      logic [3:0]  rows [3];
      key_vec_type held_scan;
      key_vec_type prev_eff;
      key_vec_type released;
      digit_type   entry_sh [CODE_DIGITS];
      digit_type   led_scan;
      logic        hold;
      logic        resume;
      logic        found;
      logic        led_found;
      logic        submit_scan;

      rows[0] = col0_rows;
      rows[1] = col1_rows;
      rows[2] = col2_rows;
      hold    = state_cur.wait_mode && !col2_rows[ENTER_ROW];
      resume  = state_cur.wait_mode && col2_rows[ENTER_ROW];

      prev_eff = resume ? '0 : state_cur.held_prev;
      for (int k = 0; k < CODE_DIGITS; k++) begin
         entry_sh[k] = resume ? DIGIT_EMPTY : entry_cur[k];
      end

      held_scan = state_cur.held;
      for (int c = 0; c < 3; c++) begin
         found = 1'b0;
         for (int r = 0; r < 4; r++) begin
            if (rows[c] == 4'd0) begin
               held_scan[COL_KEYS[c][r]] = 1'b0;
            end else if (rows[c][r] && !found) begin
               held_scan[COL_KEYS[c][r]] = 1'b1;
               found = 1'b1;
            end
         end
      end

      released = prev_eff & ~held_scan;

      for (int i = 0; i < DIGIT_KEYS; i++) begin
         if (released[i]) begin
            for (int k = 0; k < CODE_DIGITS - 1; k++) begin
               entry_sh[k] = entry_sh[k + 1];
            end
            entry_sh[CODE_DIGITS - 1] = 4'(i);
         end
      end
      if (released[KEY_CLEAR]) begin
         for (int k = 0; k < CODE_DIGITS; k++) begin
            entry_sh[k] = DIGIT_EMPTY;
         end
      end
      submit_scan = released[KEY_ENTER];

      led_scan  = 4'd0;
      led_found = 1'b0;
      for (int i = 0; i < KEY_COUNT; i++) begin
         if (held_scan[i] && !led_found) begin
            led_scan  = 4'(i);
            led_found = 1'b1;
         end
      end

      if (hold) begin
         state_next = state_cur;
         entry_next = entry_cur;
         submit     = 1'b0;
      end else begin
         state_next.held      = held_scan;
         state_next.held_prev = submit_scan ? prev_eff : held_scan;
         state_next.wait_mode = submit_scan;
         state_next.led       = submit_scan ? state_cur.led : led_scan;
         entry_next           = entry_sh;
         submit               = submit_scan;
      end
   end

endmodule

[hw/rtl/keypad_code_entry.sv]
// ----------------------------------------------------------------------------
// Keypad code entry
// Turns full scans of a 3 by 4 keypad into a code entry with submit.
// ----------------------------------------------------------------------------
// Each req_ transaction carries one complete keypad scan, one 4-bit row
// vector per column. Each scan yields exactly one rsp_ transaction with the
// LED key code, the four newest entry digits (15 when empty), the submit
// pulse and the wait flag.
// A scan is first captured in an input register; the scan logic then
// updates the key, entry and wait state from it and loads the result
// register, both while the result register is free. One scan can be
// accepted in every cycle while the receiver does not stall.
// When the receiver stalls, the result register holds its transaction, the
// input register holds the next scan, and req_ready falls only when both are
// full. Reset clears all key marks, empties the entry, leaves wait mode,
// sets the LED code to zero and drops both valid flags.
// ----------------------------------------------------------------------------
`include "keypad_code_entry_assert.svh"

module keypad_code_entry import kce_pkg::*; #(
   parameter int CODE_DIGITS = 4
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [3:0] req_col0_rows,
   input  logic [3:0] req_col1_rows,
   input  logic [3:0] req_col2_rows,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [3:0] rsp_led_code,
   output logic [3:0] rsp_digit0,
   output logic [3:0] rsp_digit1,
   output logic [3:0] rsp_digit2,
   output logic [3:0] rsp_digit3,
   output logic       rsp_submit,
   output logic       rsp_waiting
);

   logic          s1_valid_ff;
   logic [3:0]    s1_col0_ff;
   logic [3:0]    s1_col1_ff;
   logic [3:0]    s1_col2_ff;
   kce_state_type state_ff;
   kce_state_type state_in;
   digit_type     entry_ff [CODE_DIGITS];
   digit_type     entry_in [CODE_DIGITS];
   digit_type     view_in  [4];
   logic          submit_in;
   logic          rsp_valid_ff;
   digit_type     rsp_led_ff;
   digit_type     rsp_digit_ff [4];
   logic          rsp_submit_ff;
   logic          rsp_waiting_ff;
   logic          out_free;
   logic          step_fire;

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign step_fire = s1_valid_ff && out_free;
   assign req_ready = !s1_valid_ff || out_free;

   kce_step #(
      .CODE_DIGITS(CODE_DIGITS)
   ) u_step (
      .col0_rows (s1_col0_ff),
      .col1_rows (s1_col1_ff),
      .col2_rows (s1_col2_ff),
      .state_cur (state_ff),
      .entry_cur (entry_ff),
      .state_next(state_in),
      .entry_next(entry_in),
      .submit    (submit_in)
   );

   for (genvar j = 0; j < 4; j++) begin : g_view
      if (CODE_DIGITS - 4 + j >= 0) begin : g_slot
         assign view_in[j] = entry_in[CODE_DIGITS - 4 + j];
      end else begin : g_none
         assign view_in[j] = DIGIT_EMPTY;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (req_ready) begin
         s1_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         s1_col0_ff <= req_col0_rows;
         s1_col1_ff <= req_col1_rows;
         s1_col2_ff <= req_col2_rows;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= '0;
         for (int k = 0; k < CODE_DIGITS; k++) begin
            entry_ff[k] <= DIGIT_EMPTY;
         end
      end else if (step_fire) begin
         state_ff <= state_in;
         entry_ff <= entry_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_free) begin
         rsp_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (step_fire) begin
         rsp_led_ff     <= state_in.led;
         rsp_digit_ff   <= view_in;
         rsp_submit_ff  <= submit_in;
         rsp_waiting_ff <= state_in.wait_mode;
      end
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_led_code = rsp_led_ff;
   assign rsp_digit0   = rsp_digit_ff[0];
   assign rsp_digit1   = rsp_digit_ff[1];
   assign rsp_digit2   = rsp_digit_ff[2];
   assign rsp_digit3   = rsp_digit_ff[3];
   assign rsp_submit   = rsp_submit_ff;
   assign rsp_waiting  = rsp_waiting_ff;

   `KCE_ASSERT_SAME(a_submit_waits, rsp_valid_ff && rsp_submit_ff, rsp_waiting_ff,
      "A submit transaction must report wait mode.")
   `KCE_ASSERT_SAME(a_wait_from_submit, $rose(state_ff.wait_mode),
      rsp_valid_ff && rsp_submit_ff, "Wait mode entered without a submit transaction.")
   `KCE_ASSERT_NEXT(a_wait_hold, step_fire && state_ff.wait_mode && !s1_col2_ff[ENTER_ROW],
      $stable(state_ff) && !rsp_submit_ff, "Scan state changed while waiting for enter.")
   `KCE_ASSERT_SAME(a_stall_full, !req_ready,
      s1_valid_ff && rsp_valid_ff && !rsp_ready, "Input stalled while a stage was free.")

endmodule
